>>> src/kerd_pkg.sv
`default_nettype none

package kerd_pkg;

    localparam int NUM_KEYS = 256;
    localparam int ADDR_W   = $clog2(NUM_KEYS);

    localparam logic [7:0] HELD_BYTE     = 8'h80;
    localparam logic [7:0] FREE_BYTE     = 8'h00;
    localparam logic [7:0] DELAY_RESET   = 8'd50;
    localparam logic [8:0] NO_KEY        = 9'h1FF;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [7:0] hold_cnt;
        logic [7:0] prev_state;
        logic [7:0] cur_state;
    } t_entry;

    typedef struct packed {
        logic       trig;
        logic       rel;
        logic       rep;
        logic [8:0] first_key;
    } t_result;

endpackage

`default_nettype wire

>>> src/key_edge_and_repeat_detector_unit.sv
// A result passes the stage-one and output registers after its input is accepted.
// One sample per cycle unless the output stalls; the per-key record is read in the
// accept cycle, written back as it leaves stage one, and forwarded to the next read.
// Reset (synchronous, active low) empties the pipeline, marks every key record as
// unwritten so that it reads as zero, sets the repeat delay to 50 and the lowest
// triggered key to all ones. No clearing pass is needed; the block is ready at once.
`default_nettype none

module key_edge_and_repeat_detector_unit
    import kerd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [7:0]            i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // key_index [7:0], key_state [15:8]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // trigger_flag [0], release_flag [1], repeat_flag [2], first_trigger_key [11:3],
    // zero [15:12]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    t_entry              r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_valid;

    logic [7:0]          r_repeat_delay;
    logic [8:0]          r_lowest;
    logic [8:0]          n_lowest;

    logic                r_s1_vld;
    logic [7:0]          r_s1_key;
    logic [7:0]          r_s1_live;
    logic                r_s1_inr;
    logic                r_s1_ent_vld;
    t_entry              r_rd_data;

    logic                r_fw_vld;
    logic [ADDR_W-1:0]   r_fw_addr;
    t_entry              r_fw_ent;

    logic                r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                w_accept;
    logic                w_adv;
    logic [ADDR_W-1:0]   w_in_addr;
    logic [ADDR_W-1:0]   w_s1_addr;
    logic                w_in_range;
    logic                w_write;
    t_entry              w_ent;
    t_entry              n_ent;
    t_result             w_res;
    logic [7:0]          w_cnt1;
    logic                w_held;
    logic [8:0]          w_base;

    assign w_in_addr  = ADDR_W'(s_axis_tdata[7:0]);
    assign w_in_range = (32'(s_axis_tdata[7:0]) < NUM_KEYS);
    assign w_s1_addr  = ADDR_W'(r_s1_key);

    assign w_adv         = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_write       = w_adv && r_s1_inr;

    always_comb begin
        if (r_fw_vld && (r_fw_addr == w_s1_addr)) begin
            w_ent = r_fw_ent;
        end else if (r_s1_ent_vld) begin
            w_ent = r_rd_data;
        end else begin
            w_ent = '0;
        end
    end

    always_comb begin
        w_res.rel = (w_ent.cur_state == FREE_BYTE) && (w_ent.prev_state != w_ent.cur_state);
        w_res.trig = (w_ent.cur_state == HELD_BYTE) && (w_ent.prev_state != w_ent.cur_state);
        w_cnt1 = w_res.rel ? 8'd0 : w_ent.hold_cnt;
        w_held = (r_s1_live == HELD_BYTE);
        w_res.rep = w_held && ((w_cnt1 == r_repeat_delay) || (w_cnt1 == 8'd0));
        n_ent.hold_cnt   = (w_held && (w_cnt1 < r_repeat_delay)) ? w_cnt1 + 8'd1 : w_cnt1;
        n_ent.prev_state = w_ent.cur_state;
        n_ent.cur_state  = r_s1_live;
        if (!r_s1_inr) begin
            w_res.rel  = 1'b0;
            w_res.trig = 1'b0;
            w_res.rep  = 1'b0;
        end
        w_base   = (r_s1_key == 8'd0) ? NO_KEY : r_lowest;
        n_lowest = (w_res.trig && ({1'b0, r_s1_key} < w_base)) ? {1'b0, r_s1_key} : w_base;
        w_res.first_key = n_lowest;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_mem[w_in_addr];
        end
        if (w_write) begin
            r_mem[w_s1_addr] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_repeat_delay <= DELAY_RESET;
            r_lowest       <= NO_KEY;
            r_s1_vld       <= 1'b0;
            r_fw_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_repeat_delay <= i_cfg_wdata;
            end
            if (w_write) begin
                r_valid[w_s1_addr] <= 1'b1;
                r_fw_vld           <= 1'b1;
            end
            if (w_adv) begin
                r_lowest <= n_lowest;
            end
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_key     <= s_axis_tdata[7:0];
            r_s1_live    <= s_axis_tdata[15:8];
            r_s1_inr     <= w_in_range;
            r_s1_ent_vld <= r_valid[w_in_addr];
        end
        if (w_write) begin
            r_fw_addr <= w_s1_addr;
            r_fw_ent  <= n_ent;
        end
        if (w_adv) begin
            r_out_data <= {4'b0000, w_res.first_key, w_res.rep, w_res.rel, w_res.trig};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> src/kerd_checker.sv
`default_nettype none

module kerd_checker
    import kerd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_edge_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("press and release edge in the same transaction");

    a_trig_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[11:3] != NO_KEY)
        else $error("press edge without a lowest triggered key");

endmodule

bind key_edge_and_repeat_detector_unit kerd_checker u_kerd_checker (.*);

`default_nettype wire
